// ----- rtl/qte_pkg.sv -----
`timescale 1ns / 1ps
package qte_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ANG_LEN = 24;
	localparam int NW = 34;
	localparam int XW = 36;
	localparam int ZW = 34;
	localparam int SQ_STEPS = 31;
	localparam int RAD_W = 62;
	localparam int REM_W = 35;
	localparam int ROOT_W = 31;
	localparam int IDX_W = 5;

	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [16:0] PI_Q13 = 17'sd25736;
	localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;

	localparam logic [29:0] ATAN_TAB [ANG_LEN] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
		30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
		30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
		30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255, 30'd127
	};

	typedef struct packed {
		logic signed [NW-1:0] num_r;
		logic signed [NW-1:0] den_r;
		logic signed [NW-1:0] num_y;
		logic signed [NW-1:0] den_y;
		logic signed [31:0]   s;
	} side_t;

	typedef struct packed {
		logic [RAD_W-1:0]  v;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		side_t             side;
	} sqrt_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} cord_t;

endpackage

// ----- rtl/qte_sqrt_cell.sv -----
`timescale 1ns / 1ps
module qte_sqrt_cell (
	input  logic            clk,
	input  logic            adv,
	input  qte_pkg::sqrt_t  d,
	output qte_pkg::sqrt_t  q
);
	logic [qte_pkg::REM_W-1:0] rem_n;
	logic [qte_pkg::REM_W-1:0] test;
	logic                      ge;

	always_comb begin
		rem_n = {d.rem[qte_pkg::REM_W-3:0], d.v[qte_pkg::RAD_W-1:qte_pkg::RAD_W-2]};
		test  = {2'b00, d.root, 2'b01};
		ge    = rem_n >= test;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q.rem  <= ge ? rem_n - test : rem_n;
			q.root <= {d.root[qte_pkg::ROOT_W-2:0], ge};
			q.v    <= {d.v[qte_pkg::RAD_W-3:0], 2'b00};
			q.side <= d.side;
		end
	end
endmodule

// ----- rtl/qte_cordic_cell.sv -----
`timescale 1ns / 1ps
module qte_cordic_cell (
	input  logic                       clk,
	input  logic                       adv,
	input  logic [qte_pkg::IDX_W-1:0]  idx,
	input  qte_pkg::cord_t             d,
	output qte_pkg::cord_t             q
);
	logic signed [qte_pkg::XW-1:0] xs;
	logic signed [qte_pkg::XW-1:0] ys;
	logic signed [qte_pkg::ZW-1:0] ang;

	always_comb begin
		xs  = d.x >>> idx;
		ys  = d.y >>> idx;
		ang = signed'({{(qte_pkg::ZW-30){1'b0}}, qte_pkg::ATAN_TAB[idx]});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q.zero <= d.zero;
			if (!d.y[qte_pkg::XW-1]) begin
				q.x <= d.x + ys;
				q.y <= d.y - xs;
				q.z <= d.z + ang;
			end else begin
				q.x <= d.x - ys;
				q.y <= d.y + xs;
				q.z <= d.z - ang;
			end
		end
	end
endmodule

// ----- rtl/quaternion_to_euler_angles_core.sv -----
`timescale 1ns / 1ps
// channel | dir | handshake          | payload
// cfg     | in  | cfg_we             | cfg_wdata: enable
// s       | in  | s_tvalid/s_tready  | s_tdata: quat_x, quat_y, quat_z, quat_w
// m       | out | m_tvalid/m_tready  | m_tdata: roll_angle, pitch_angle, yaw_angle
// one beat per cycle sustained while the output is not stalled
// the path runs through the 31-cell square-root chain and the CORDIC cell chains
// arst_n clears valid bits, output valid and enable
// a stalled output holds the chain only when its last cell carries an item
module quaternion_to_euler_angles_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // roll_angle, pitch_angle, yaw_angle, pad
);
	localparam int N  = qte_pkg::CORDIC_STEPS;
	localparam int SQ = qte_pkg::SQ_STEPS;
	localparam int NV = 4 + SQ + N;

	logic          enable_q;
	logic [NV-1:0] vld_q;
	logic          adv;
	logic          out_valid_q;
	logic [47:0]   out_data_q;

	logic signed [15:0] qx, qy, qz, qw;
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, zx_s1;
	qte_pkg::side_t     side_s2;
	logic signed [32:0] sum_a, sum_b, sum_c, sum_d, sum_e, sum_f;
	logic signed [33:0] t_s;
	logic signed [31:0] s_c;
	qte_pkg::side_t     side_s3;
	logic signed [63:0] sq_full;
	logic [60:0]        sq_s3;

	qte_pkg::sqrt_t     sq_d [SQ+1];
	qte_pkg::cord_t     cr [N+1];
	qte_pkg::cord_t     cp [N+1];
	qte_pkg::cord_t     cy [N+1];
	qte_pkg::cord_t     pr_c, pp_c, py_c;
	logic signed [16:0] roll_r, pitch_r, yaw_r;

	function automatic qte_pkg::cord_t prep(input logic signed [qte_pkg::XW-1:0] y,
			input logic signed [qte_pkg::XW-1:0] x);
		qte_pkg::cord_t c;
		c.zero = (x == '0) && (y == '0);
		c.x = x;
		c.y = y;
		c.z = '0;
		if (x[qte_pkg::XW-1]) begin
			if (!y[qte_pkg::XW-1]) begin
				c.x = y;
				c.y = -x;
				c.z = qte_pkg::HALF_PI_Q30;
			end else begin
				c.x = -y;
				c.y = x;
				c.z = -qte_pkg::HALF_PI_Q30;
			end
		end
		return c;
	endfunction

	function automatic logic signed [qte_pkg::XW-1:0] ext(input logic signed [qte_pkg::NW-1:0] v);
		return {{(qte_pkg::XW-qte_pkg::NW){v[qte_pkg::NW-1]}}, v};
	endfunction

	function automatic logic signed [16:0] rnd(input qte_pkg::cord_t c,
			input logic signed [16:0] lim);
		logic signed [qte_pkg::ZW-1:0] t;
		logic signed [16:0] r;
		t = c.z + qte_pkg::ZW'(1 << 16);
		r = t[qte_pkg::ZW-1:17];
		if (c.zero)
			r = '0;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	assign adv      = !vld_q[NV-1] || !out_valid_q || m_tready;
	assign s_tready = adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			enable_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NV-2:0], s_tvalid & enable_q};
		end
	end

	// products
	always_comb begin
		qx = s_tdata[15:0];
		qy = s_tdata[31:16];
		qz = s_tdata[47:32];
		qw = s_tdata[63:48];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wx_s1 <= qw * qx;
			yz_s1 <= qy * qz;
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			wz_s1 <= qw * qz;
			xy_s1 <= qx * qy;
			zz_s1 <= qz * qz;
			wy_s1 <= qw * qy;
			zx_s1 <= qz * qx;
		end
	end

	// sums and sine clamp
	always_comb begin
		sum_a = {wx_s1[31], wx_s1} + {yz_s1[31], yz_s1};
		sum_b = {xx_s1[31], xx_s1} + {yy_s1[31], yy_s1};
		sum_c = {wz_s1[31], wz_s1} + {xy_s1[31], xy_s1};
		sum_d = {yy_s1[31], yy_s1} + {zz_s1[31], zz_s1};
		sum_e = {wy_s1[31], wy_s1} - {zx_s1[31], zx_s1};
		sum_f = sum_e;
		t_s   = {sum_f, 1'b0};
		if (t_s > 34'sd1073741824)
			s_c = 32'sd1073741824;
		else if (t_s < -34'sd1073741824)
			s_c = -32'sd1073741824;
		else
			s_c = t_s[31:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2.num_r <= {sum_a, 1'b0};
			side_s2.den_r <= 34'sd1073741824 - {sum_b, 1'b0};
			side_s2.num_y <= {sum_c, 1'b0};
			side_s2.den_y <= 34'sd1073741824 - {sum_d, 1'b0};
			side_s2.s     <= s_c;
		end
	end

	// sine squared
	assign sq_full = side_s2.s * side_s2.s;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s3   <= sq_full[60:0];
			side_s3 <= side_s2;
		end
	end

	always_comb begin
		sq_d[0].v    = 62'h1000_0000_0000_0000 - {1'b0, sq_s3};
		sq_d[0].rem  = '0;
		sq_d[0].root = '0;
		sq_d[0].side = side_s3;
	end

	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		qte_sqrt_cell u_cell (
			.clk (clk),
			.adv (adv),
			.d   (sq_d[k]),
			.q   (sq_d[k+1])
		);
	end

	// quadrant fold
	always_comb begin
		pr_c = prep(ext(sq_d[SQ].side.num_r), ext(sq_d[SQ].side.den_r));
		py_c = prep(ext(sq_d[SQ].side.num_y), ext(sq_d[SQ].side.den_y));
		pp_c = prep({{(qte_pkg::XW-32){sq_d[SQ].side.s[31]}}, sq_d[SQ].side.s},
			signed'({{(qte_pkg::XW-qte_pkg::ROOT_W){1'b0}}, sq_d[SQ].root}));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cr[0] <= pr_c;
			cp[0] <= pp_c;
			cy[0] <= py_c;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		localparam logic [qte_pkg::IDX_W-1:0] IDX = qte_pkg::IDX_W'(i);
		qte_cordic_cell u_roll (.clk(clk), .adv(adv), .idx(IDX), .d(cr[i]), .q(cr[i+1]));
		qte_cordic_cell u_pitch (.clk(clk), .adv(adv), .idx(IDX), .d(cp[i]), .q(cp[i+1]));
		qte_cordic_cell u_yaw (.clk(clk), .adv(adv), .idx(IDX), .d(cy[i]), .q(cy[i+1]));
	end

	always_comb begin
		roll_r  = rnd(cr[N], qte_pkg::PI_Q13);
		pitch_r = rnd(cp[N], qte_pkg::HALF_PI_Q13);
		yaw_r   = rnd(cy[N], qte_pkg::PI_Q13);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			if (adv && vld_q[NV-1])
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_q[NV-1]) begin
			out_data_q <= {1'b0, yaw_r[15:0], pitch_r[14:0], roll_r[15:0]};
		end
	end
endmodule

// ----- rtl/qte_checker.sv -----
`timescale 1ns / 1ps
module qte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);
	// stalled beat stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[30:16]) <= 15'sd12868) &&
			($signed(m_tdata[30:16]) >= -15'sd12868))
		else $error("pitch out of range");

	a_roll: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd25736) &&
			($signed(m_tdata[15:0]) >= -16'sd25736))
		else $error("roll out of range");
endmodule

bind quaternion_to_euler_angles_core qte_checker u_qte_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

	typedef struct {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
	} angles_t;

	typedef struct {
		logic signed [15:0] qx, qy, qz, qw;
		bit                 typed;
		angles_t            ang;
	} stim_row_t;

	localparam longint ONE_Q30 = 64'sd1 << 30;
	localparam int LATENCY = 36 + qte_pkg::CORDIC_STEPS;
	localparam int WATCHDOG_LIMIT = 4000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;

	angles_t angle_queue[$];
	bit      enabled;
	bit      quiet;
	int      mismatches;
	int      stall_count;
	bit      failed;

	quaternion_to_euler_angles_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint vec_atan2(longint y, longint x);
		longint z, t, xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = qte_pkg::HALF_PI_Q30;
			end else begin
				x = -y;
				y = t;
				z = -qte_pkg::HALF_PI_Q30;
			end
		end
		for (int i = 0; i < qte_pkg::CORDIC_STEPS && i < qte_pkg::ANG_LEN; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(qte_pkg::ATAN_TAB[i]);
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(qte_pkg::ATAN_TAB[i]);
			end
		end
		return z;
	endfunction

	function automatic longint round_q13(longint a, longint lim);
		longint r;
		r = (a + (64'sd1 <<< 16)) >>> 17;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic angles_t euler_of(logic signed [15:0] qx, logic signed [15:0] qy,
			logic signed [15:0] qz, logic signed [15:0] qw);
		longint x, y, z, w, num, den, s, r;
		angles_t a;
		x = qx; y = qy; z = qz; w = qw;
		num = 2 * (w * x + y * z);
		den = ONE_Q30 - 2 * (x * x + y * y);
		r = round_q13(vec_atan2(num, den), qte_pkg::PI_Q13);
		a.roll = r[15:0];
		s = 2 * (w * y - z * x);
		if (s > ONE_Q30) s = ONE_Q30;
		if (s < -ONE_Q30) s = -ONE_Q30;
		r = round_q13(vec_atan2(s, longint'(int_sqrt((64'd1 << 60) - s * s))),
			qte_pkg::HALF_PI_Q13);
		a.pitch = r[14:0];
		num = 2 * (w * z + x * y);
		den = ONE_Q30 - 2 * (y * y + z * z);
		r = round_q13(vec_atan2(num, den), qte_pkg::PI_Q13);
		a.yaw = r[15:0];
		return a;
	endfunction

	task automatic send_quat(logic signed [15:0] qx, logic signed [15:0] qy,
			logic signed [15:0] qz, logic signed [15:0] qw, bit typed, angles_t ang);
		bit offered;
		offered = 1'b0;
		forever begin
			@(negedge clk);
			if (!offered && !quiet && $urandom_range(99) < 16) begin
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= {qw, qz, qy, qx};
				offered = 1'b1;
			end
			@(posedge clk);
			if (s_tvalid && s_tready) break;
		end
		if (enabled) angle_queue.push_back(typed ? ang : euler_of(qx, qy, qz, qw));
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (angle_queue.size() == 0);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_enable(bit v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		enabled = v;
	endtask

	task automatic random_quat(output logic signed [15:0] qx, output logic signed [15:0] qy,
			output logic signed [15:0] qz, output logic signed [15:0] qw);
		real a, b, c, d, n;
		if ($urandom_range(3) == 0) begin
			qx = 16'($urandom); qy = 16'($urandom); qz = 16'($urandom); qw = 16'($urandom);
		end else begin
			a = real'($urandom_range(20000)) - 10000.0;
			b = real'($urandom_range(20000)) - 10000.0;
			c = real'($urandom_range(20000)) - 10000.0;
			d = real'($urandom_range(20000)) - 10000.0;
			n = $sqrt(a * a + b * b + c * c + d * d) + 1.0e-9;
			qx = 16'($rtoi(a / n * 32767.0));
			qy = 16'($rtoi(b / n * 32767.0));
			qz = 16'($rtoi(c / n * 32767.0));
			qw = 16'($rtoi(d / n * 32767.0));
		end
	endtask

	always @(negedge clk) begin
		m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 16);
	end

	always @(posedge clk) begin
		angles_t want;
		logic signed [15:0] r, y;
		logic signed [14:0] p;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_count <= 0;
			else stall_count <= stall_count + 1;
			if (stall_count >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
		if (arst_n && m_tvalid && m_tready) begin
			r = m_tdata[15:0];
			p = m_tdata[30:16];
			y = m_tdata[46:31];
			if (angle_queue.size() == 0) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %h", m_tdata);
			end else begin
				want = angle_queue.pop_front();
				if (r !== want.roll || p !== want.pitch || y !== want.yaw) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %0d %0d %0d got %0d %0d %0d",
							want.roll, want.pitch, want.yaw, r, p, y);
				end
			end
		end
	end

	stim_row_t rows[] = '{
		'{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b1, '{16'sd0, 15'sd0, 16'sd0}},
		'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 15'sd0, 16'sd0}},
		'{16'sd0, 16'sd0, 16'sd0, -16'sd32768, 1'b0, '{0, 0, 0}},
		'{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0, '{0, 0, 0}},
		'{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 1'b0, '{0, 0, 0}},
		'{16'sd0, 16'sd32767, 16'sd0, 16'sd0, 1'b0, '{0, 0, 0}},
		'{16'sd0, 16'sd0, 16'sd32767, 16'sd0, 1'b0, '{0, 0, 0}},
		'{16'sd0, 16'sd0, -16'sd32768, 16'sd0, 1'b0, '{0, 0, 0}},
		'{16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 1'b0, '{0, 0, 0}},
		'{16'sd23170, 16'sd0, 16'sd0, 16'sd23170, 1'b0, '{0, 0, 0}},
		'{-16'sd23170, 16'sd0, 16'sd0, 16'sd23170, 1'b0, '{0, 0, 0}},
		'{16'sd0, 16'sd23170, 16'sd0, 16'sd23170, 1'b0, '{0, 0, 0}},
		'{16'sd0, -16'sd23170, 16'sd0, 16'sd23170, 1'b0, '{0, 0, 0}},
		'{16'sd0, 16'sd32767, 16'sd0, 16'sd32767, 1'b0, '{0, 0, 0}},
		'{16'sd0, -16'sd32768, 16'sd0, 16'sd32767, 1'b0, '{0, 0, 0}},
		'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '{0, 0, 0}},
		'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '{0, 0, 0}},
		'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1'b0, '{0, 0, 0}},
		'{16'sd1, 16'sd0, 16'sd0, -16'sd1, 1'b0, '{0, 0, 0}},
		'{-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, '{0, 0, 0}},
		'{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b0, '{0, 0, 0}}
	};

	initial begin
		logic signed [15:0] qx, qy, qz, qw;
		angles_t none;
		none = '{0, 0, 0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		enabled = 1'b0;
		quiet = 1'b0;
		mismatches = 0;
		stall_count = 0;
		failed = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// enable is clear after reset, so these are dropped
		for (int i = 0; i < 8; i++) begin
			random_quat(qx, qy, qz, qw);
			send_quat(qx, qy, qz, qw, 1'b0, none);
		end
		drain();
		write_enable(1'b1);
		foreach (rows[i])
			send_quat(rows[i].qx, rows[i].qy, rows[i].qz, rows[i].qw, rows[i].typed, rows[i].ang);

		for (int i = 0; i < 1500; i++) begin
			quiet = (i >= 400 && i < 700);
			if (i == 900) begin
				drain();
				write_enable(1'b0);
			end
			if (i == 960) begin
				drain();
				write_enable(1'b1);
			end
			random_quat(qx, qy, qz, qw);
			send_quat(qx, qy, qz, qw, 1'b0, none);
		end
		drain();

		if (!failed) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- quaternion_to_euler_angles_core.f -----
rtl/qte_pkg.sv
rtl/qte_sqrt_cell.sv
rtl/qte_cordic_cell.sv
rtl/quaternion_to_euler_angles_core.sv
rtl/qte_checker.sv
verif/testbench.sv
